FILE: rtl/core/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

  // Width of the converted value (valid range 4..64).
  localparam int NUMBER_WIDTH = 32;

  // Decimal digits of the largest value: floor(W * log10(2)) + 1.
  localparam int NUM_DIGITS = ((NUMBER_WIDTH * 1233) >> 12) + 1;

  localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W   = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

FILE: rtl/core/binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Bit-serial binary to decimal ASCII converter, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/number) takes one unsigned value per
//   transaction. Output channel (out_valid/out_ready/digit_char/last_digit)
//   returns the decimal digits as ASCII, most significant first, with no
//   leading zeros; last_digit marks the final character. Zero gives one '0'.
//   Only one value is in flight: in_ready is high only while idle.
// Conversion and throughput:
//   Conversion runs a shift-add-3 (double dabble) pass, one binary bit per
//   cycle over all NUMBER_WIDTH (32) bits. Leading zero digits are then dropped
//   one per cycle (up to NUM_DIGITS-1 = 9), the leading digit is found, and
//   each digit is held on the output until out_ready takes it. A new value is
//   taken only after the last character of the previous one has gone out.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle and drops
//   any partly converted value.
// Stalls:
//   When out_ready is low the current character and its flag hold steady;
//   the block simply waits, nothing is lost.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bda_pkg::NUMBER_WIDTH-1:0] number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      digit_char,
  output logic                            last_digit
);
  import bda_pkg::*;

  state_t                   state, state_next;
  logic [NUMBER_WIDTH-1:0]  bin_sr;
  logic [BCD_WIDTH-1:0]     bcd;
  logic [BCD_WIDTH-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0]     bit_cnt;
  logic [DIGIT_CNT_W-1:0]   digits_left;
  logic [3:0]               top_digit;

  // Add-3 correction on every BCD digit; each digit is an independent lane.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd[BCD_WIDTH-1 -: 4];

  // Sequencer: idle -> convert -> drop leading zeros -> emit characters.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (bit_cnt == BIT_CNT_W'(NUMBER_WIDTH - 1)) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_digit != 4'd0 || digits_left == DIGIT_CNT_W'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready && digits_left == DIGIT_CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: binary shifter, BCD accumulator and counters.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // Load a new value and clear the accumulator.
        bin_sr      <= number;
        bcd         <= '0;
        bit_cnt     <= '0;
        digits_left <= DIGIT_CNT_W'(NUM_DIGITS);
      end
      S_CONV: begin
        // Correct, then shift one binary bit into the BCD register.
        bcd     <= {bcd_adj[BCD_WIDTH-2:0], bin_sr[NUMBER_WIDTH-1]};
        bin_sr  <= {bin_sr[NUMBER_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      S_SKIP: begin
        // Drop a leading zero digit, keeping at least one.
        if (top_digit == 4'd0 && digits_left != DIGIT_CNT_W'(1)) begin
          bcd         <= {bcd[BCD_WIDTH-5:0], 4'd0};
          digits_left <= digits_left - DIGIT_CNT_W'(1);
        end
      end
      S_EMIT: begin
        // Advance to the next digit once the current one is taken.
        if (out_ready) begin
          bcd         <= {bcd[BCD_WIDTH-5:0], 4'd0};
          digits_left <= digits_left - DIGIT_CNT_W'(1);
        end
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_EMIT);
  assign digit_char = ASCII_ZERO + {2'b00, top_digit};
  assign last_digit = (digits_left == DIGIT_CNT_W'(1));

endmodule

FILE: rtl/core/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
module bda_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [5:0]                      digit_char,
  input logic                            last_digit
);

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
    else $error("output transaction changed while stalled");

  // Only decimal digit codes appear.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
    else $error("digit_char outside '0'..'9'");

  // One value at a time: no input taken while characters are pending.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while output pending");

  // An accepted value closes the input: in_ready drops after the transaction.
  a_in_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after transaction");

  // The final character ends the run.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_digit |=> !out_valid)
    else $error("output continued after last digit");

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .digit_char (digit_char),
  .last_digit (last_digit)
);
